// ----- hdl/timer_prescaler_reload_calc_macros.svh -----
// ----------------------------------------------------------------------------
// Timer prescaler reload calculator assertion macros
// Small wrappers around concurrent assertions clocked by clk and disabled
// while rst_n is low. They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIMER_PRESCALER_RELOAD_CALC_MACROS_SVH
`define TIMER_PRESCALER_RELOAD_CALC_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TPRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer prescaler reload calc: assertion failed");

// Next-cycle implication.
`define TPRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer prescaler reload calc: assertion failed");

`else

`define TPRC_ASSERT_SAME(label, ante, cons)
`define TPRC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/tprc_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer prescaler reload calculator package
// Field widths, control byte constants, status codes and sequencer states.
// ----------------------------------------------------------------------------
package tprc_pkg;

  localparam int unsigned LINES_W   = 8;
  localparam int unsigned REFRESH_W = 10;
  localparam int unsigned RATE_W    = LINES_W + REFRESH_W;
  localparam int unsigned CLK_W     = 32;
  localparam int unsigned CNT_W     = $clog2(CLK_W);

  localparam logic [CLK_W-1:0] CLK_RESET  = 32'd2000000;
  localparam logic [CLK_W-1:0] TICK_LIMIT = 32'h0001_0000;
  localparam logic [7:0]       CTL_ENABLE = 8'h80;
  localparam logic [2:0]       PS_MAX     = 3'b111;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_TOO_LOW  = 2'd2;
  localparam logic [1:0] ST_TOO_HIGH = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_NORM = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

endpackage

// ----- hdl/timer_prescaler_reload_calc.sv -----
// ----------------------------------------------------------------------------
// Timer prescaler and reload calculator
// For one display mode, works out the 16-bit timer preload and prescaler
// setting that give one timer overflow per scanline.
// ----------------------------------------------------------------------------
// Usage:
// A mode word enters on the in_ channel (scan line count and refresh rate).
// The block forms the line rate as lines times refresh, divides the timer
// clock held in the configuration register by it to get ticks per line, then
// halves the ticks and steps the prescaler until they are at most 65536. One
// result word leaves on the out_ channel: preload bytes and control byte in
// out_tdata, status code in out_tuser.
// The word is taken in S_IDLE, lines times refresh is formed in S_MUL, the
// restoring division runs in S_DIV (one quotient bit per cycle through the
// subtractor), S_NORM normalizes and S_FIN loads the output register. A zero
// field skips the arithmetic and goes straight from S_IDLE to S_FIN.
// Only one word is in work at a time, so in_tready is high only when idle.
// The output register lets the next word be taken while a result still
// waits; if the receiver stalls, the finished result holds in the sequencer
// until the output register frees up. The configuration channel is always
// ready and should only be written while the block is idle.
// Reset (rst_n low, synchronous) empties the output and sets the timer clock
// to 2 MHz.
// ----------------------------------------------------------------------------
`include "timer_prescaler_reload_calc_macros.svh"

module timer_prescaler_reload_calc (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel: timer clock frequency in hertz.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] scan_lines, [17:8] refresh_hz, rest zero
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] preload_high, [15:8] preload_low,
                                  // [23:16] control_byte
  output logic [1:0]  out_tuser   // [1:0] status
);

  tprc_pkg::state_t state_r, state_nxt;

  logic [tprc_pkg::CLK_W-1:0]     clk_hz_r;
  logic [tprc_pkg::LINES_W-1:0]   lines_r, lines_nxt;
  logic [tprc_pkg::REFRESH_W-1:0] refresh_r, refresh_nxt;
  logic [tprc_pkg::RATE_W-1:0]    div_r, div_nxt;
  logic [tprc_pkg::RATE_W-1:0]    rem_r, rem_nxt;
  logic [tprc_pkg::CLK_W-1:0]     q_r, q_nxt;
  logic [tprc_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           bypass_r, bypass_nxt;
  logic [2:0]                     ps_r, ps_nxt;
  logic [23:0]                    res_data_r, res_data_nxt;
  logic [1:0]                     res_st_r, res_st_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [23:0]                    out_data_r, out_data_nxt;
  logic [1:0]                     out_user_r, out_user_nxt;

  logic                           in_fire;
  logic                           out_free;
  logic [tprc_pkg::RATE_W+1:0]    trial;
  logic                           borrow;
  logic                           ticks_big;
  logic [15:0]                    preload;
  logic [7:0]                     ctl_byte;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == tprc_pkg::S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The subtractor: one restoring division step per cycle.
  assign trial  = {1'b0, rem_r, q_r[tprc_pkg::CLK_W-1]} - {2'b00, div_r};
  assign borrow = trial[tprc_pkg::RATE_W+1];

  assign ticks_big = (q_r > tprc_pkg::TICK_LIMIT);
  assign preload   = 16'(tprc_pkg::TICK_LIMIT - q_r);
  assign ctl_byte  = tprc_pkg::CTL_ENABLE | {4'h0, bypass_r, ps_r};

  always_comb begin
    state_nxt     = state_r;
    lines_nxt     = lines_r;
    refresh_nxt   = refresh_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    bypass_nxt    = bypass_r;
    ps_nxt        = ps_r;
    res_data_nxt  = res_data_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    unique case (state_r)
      tprc_pkg::S_IDLE: begin
        if (in_fire) begin
          lines_nxt   = in_tdata[tprc_pkg::LINES_W-1:0];
          refresh_nxt = in_tdata[tprc_pkg::LINES_W +: tprc_pkg::REFRESH_W];
          if (in_tdata[tprc_pkg::LINES_W-1:0] == '0 ||
              in_tdata[tprc_pkg::LINES_W +: tprc_pkg::REFRESH_W] == '0) begin
            res_data_nxt = '0;
            res_st_nxt   = tprc_pkg::ST_ZERO;
            state_nxt    = tprc_pkg::S_FIN;
          end else begin
            state_nxt = tprc_pkg::S_MUL;
          end
        end
      end
      tprc_pkg::S_MUL: begin
        div_nxt    = lines_r * refresh_r;
        rem_nxt    = '0;
        q_nxt      = clk_hz_r;
        cnt_nxt    = '0;
        bypass_nxt = 1'b1;
        ps_nxt     = '0;
        state_nxt  = tprc_pkg::S_DIV;
      end
      tprc_pkg::S_DIV: begin
        // Dividend bits shift out of the top of q_r as quotient bits enter.
        rem_nxt = borrow ? {rem_r[tprc_pkg::RATE_W-2:0], q_r[tprc_pkg::CLK_W-1]}
                         : trial[tprc_pkg::RATE_W-1:0];
        q_nxt   = {q_r[tprc_pkg::CLK_W-2:0], !borrow};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tprc_pkg::CNT_W'(tprc_pkg::CLK_W - 1)) begin
          state_nxt = tprc_pkg::S_NORM;
        end
      end
      tprc_pkg::S_NORM: begin
        if (ticks_big) begin
          if (ps_r == tprc_pkg::PS_MAX) begin
            res_data_nxt = '0;
            res_st_nxt   = tprc_pkg::ST_TOO_LOW;
            state_nxt    = tprc_pkg::S_FIN;
          end else begin
            q_nxt = {1'b0, q_r[tprc_pkg::CLK_W-1:1]};
            if (bypass_r) begin
              bypass_nxt = 1'b0;
            end else begin
              ps_nxt = ps_r + 1'b1;
            end
          end
        end else if (q_r == '0) begin
          res_data_nxt = '0;
          res_st_nxt   = tprc_pkg::ST_TOO_HIGH;
          state_nxt    = tprc_pkg::S_FIN;
        end else begin
          res_data_nxt = {ctl_byte, preload[7:0], preload[15:8]};
          res_st_nxt   = tprc_pkg::ST_OK;
          state_nxt    = tprc_pkg::S_FIN;
        end
      end
      tprc_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_user_nxt  = res_st_r;
          state_nxt     = tprc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tprc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tprc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      clk_hz_r    <= tprc_pkg::CLK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        clk_hz_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lines_r    <= lines_nxt;
    refresh_r  <= refresh_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    bypass_r   <= bypass_nxt;
    ps_r       <= ps_nxt;
    res_data_r <= res_data_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // A taken word keeps the block busy for at least the next cycle.
  `TPRC_ASSERT_NEXT(a_busy_after_take, in_fire, !in_tready)
  // Any error status carries all-zero bytes.
  `TPRC_ASSERT_SAME(a_err_zero, out_valid_r && out_user_r != tprc_pkg::ST_OK, out_data_r == '0)
  // A good result always has the enable bit set and bits 6..4 clear.
  `TPRC_ASSERT_SAME(a_ok_ctl, out_valid_r && out_user_r == tprc_pkg::ST_OK, out_data_r[23:20] == 4'h8)
  // The division runs only with a nonzero divisor.
  `TPRC_ASSERT_SAME(a_div_nonzero, state_r == tprc_pkg::S_DIV, div_r != '0)

endmodule

// ----- tb/timer_prescaler_reload_calc_checker.sv -----
// ----------------------------------------------------------------------------
// Timer prescaler reload calculator checker
// Watches the configuration, input and result channels of the calculator,
// predicts the preload bytes, control byte and status of every accepted mode
// word and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module timer_prescaler_reload_calc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] scan_lines, [17:8] refresh_hz, rest zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] preload_high, [15:8] preload_low,
                                  // [23:16] control_byte
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          pending
);

  localparam logic [7:0] CTL_BYPASS = 8'h08;

  typedef struct packed {
    logic [7:0] preload_high;
    logic [7:0] preload_low;
    logic [7:0] control_byte;
    logic [1:0] status;
  } timer_setting_t;

  timer_setting_t                   expected_settings[$];
  timer_setting_t                   want;
  logic [tprc_pkg::CLK_W-1:0]       timer_clock_hz;

  // Ticks per scanline, halved with each prescaler step until they fit.
  function automatic timer_setting_t compute_timer_setting(
    input logic [tprc_pkg::LINES_W-1:0]   lines,
    input logic [tprc_pkg::REFRESH_W-1:0] refresh,
    input logic [tprc_pkg::CLK_W-1:0]     clock_hz
  );
    logic [tprc_pkg::RATE_W-1:0] rate;
    logic [tprc_pkg::CLK_W-1:0]  ticks;
    logic [tprc_pkg::CLK_W-1:0]  preload;
    logic                        bypass;
    logic [2:0]                  ratio_sel;
    timer_setting_t              s;
    s = '0;
    if (lines == 0 || refresh == 0) begin
      s.status = tprc_pkg::ST_ZERO;
      return s;
    end
    rate      = lines * refresh;
    ticks     = clock_hz / rate;
    bypass    = 1'b1;
    ratio_sel = 3'd0;
    while (ticks > tprc_pkg::TICK_LIMIT) begin
      if (ratio_sel == tprc_pkg::PS_MAX) begin
        s.status = tprc_pkg::ST_TOO_LOW;
        return s;
      end
      ticks = ticks >> 1;
      if (bypass) begin
        bypass = 1'b0;
      end else begin
        ratio_sel = ratio_sel + 3'd1;
      end
    end
    if (ticks == 0) begin
      s.status = tprc_pkg::ST_TOO_HIGH;
      return s;
    end
    preload        = tprc_pkg::TICK_LIMIT - ticks;
    s.preload_high = preload[15:8];
    s.preload_low  = preload[7:0];
    s.control_byte = tprc_pkg::CTL_ENABLE | (bypass ? CTL_BYPASS : 8'h00) |
                     {5'd0, ratio_sel};
    s.status       = tprc_pkg::ST_OK;
    return s;
  endfunction

  // Appends one prediction behind the ones still waiting.
  task automatic add_expected(input timer_setting_t s);
    expected_settings.insert(expected_settings.size(), s);
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned got_val);
    $display("[%0t] mismatch: %s expected 0x%0h got 0x%0h", $time, what, exp_val, got_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timer_clock_hz = tprc_pkg::CLK_RESET;
      expected_settings.delete();
    end else begin
      // A result leaving at the same edge as a new word arrives belongs to an
      // older word, so it is compared before the new prediction is queued.
      if (out_tvalid && out_tready) begin
        if (expected_settings.size() == 0) begin
          report_mismatch("result word with nothing pending", 0, {out_tuser, out_tdata});
        end else begin
          want = expected_settings.pop_front();
          if (out_tdata[7:0] !== want.preload_high)
            report_mismatch("preload_high", want.preload_high, out_tdata[7:0]);
          if (out_tdata[15:8] !== want.preload_low)
            report_mismatch("preload_low", want.preload_low, out_tdata[15:8]);
          if (out_tdata[23:16] !== want.control_byte)
            report_mismatch("control_byte", want.control_byte, out_tdata[23:16]);
          if (out_tuser !== want.status)
            report_mismatch("status", want.status, out_tuser);
        end
      end
      if (in_tvalid && in_tready)
        add_expected(compute_timer_setting(in_tdata[7:0], in_tdata[17:8], timer_clock_hz));
      if (cfg_valid && cfg_ready)
        timer_clock_hz = cfg_data;
    end
    pending = expected_settings.size();
  end

endmodule

// ----- tb/timer_prescaler_reload_calc_test.sv -----
// ----------------------------------------------------------------------------
// Timer prescaler reload calculator testbench
// Drives mode words and timer clock settings into the calculator, lets a
// checker beside it predict and compare every result word, and gives the
// verdict. A directed part covers zero fields, the largest rate, refresh
// rates too low and too high and the exact tick limit; random phases follow,
// each with its own timer clock setting.
// ----------------------------------------------------------------------------
module timer_prescaler_reload_calc_test;

  // The receiver holds off this long once, so that the block fills up.
  localparam int HOLD_CYCLES     = 200;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 216;
  // Covers the longest path through the block, with margin.
  localparam int SETTLE_CYCLES   = 60;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] scan_lines, [17:8] refresh_hz, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] preload_high, [15:8] preload_low,
                           // [23:16] control_byte
  logic [1:0]  out_tuser;  // [1:0] status

  int fail_count;
  int pending;

  // Shared between the sender and the receiver: quiet turns off all idling
  // for the last phase, hold_req asks the receiver for one long hold-off.
  bit quiet;
  bit hold_req;

  timer_prescaler_reload_calc uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  timer_prescaler_reload_calc_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // A hung handshake or a lost result ends the run here, with room to spare
  // over the slowest correct run.
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // Every task below starts and ends at a falling edge. Handshakes are
  // sampled right after the rising edge, before the block's registers move.

  // Offers one mode word, after an optional idle burst.
  // The valid stays high between back-to-back words, so it is only ever
  // assigned once in a time step.
  task automatic send_mode(input logic [7:0] lines, input logic [9:0] refresh);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, refresh, lines};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering words and waits until every predicted result has come.
  // Each word yields a result, so the block is idle at that point.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Writes the timer clock register, only ever with the block idle.
  task automatic write_timer_clock(input logic [31:0] hz);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts, one long hold-off on request, and none at
  // all once the run goes quiet.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [31:0] clk_hz;
    logic [7:0]  lines;
    logic [9:0]  refresh;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset clock of 2 MHz: zero fields in every combination, the largest
    // rate and a few ordinary modes.
    send_mode(8'd0, 10'd60);
    send_mode(8'd64, 10'd0);
    send_mode(8'd0, 10'd0);
    send_mode(8'd255, 10'd0);
    send_mode(8'd0, 10'd1023);
    send_mode(8'd255, 10'd1023);
    send_mode(8'd1, 10'd1);
    send_mode(8'd16, 10'd50);
    send_mode(8'd32, 10'd60);

    // A 1 Hz clock: one tick is fine, any larger rate is too high.
    write_timer_clock(32'd1);
    send_mode(8'd1, 10'd1);
    send_mode(8'd2, 10'd1);
    send_mode(8'd255, 10'd1023);

    // Ticks exactly at the limit are taken as they are, with zero preload.
    write_timer_clock(tprc_pkg::TICK_LIMIT);
    send_mode(8'd1, 10'd1);
    send_mode(8'd1, 10'd2);

    // One tick over the limit takes a single halving and clears the bypass.
    write_timer_clock(tprc_pkg::TICK_LIMIT + 32'd1);
    send_mode(8'd1, 10'd1);

    // The fastest clock: small rates run out of prescaler steps.
    write_timer_clock(32'hFFFF_FFFF);
    send_mode(8'd1, 10'd1);
    send_mode(8'd1, 10'd255);
    send_mode(8'd255, 10'd1023);
    send_mode(8'd128, 10'd512);
    send_mode(8'd0, 10'd512);

    // Random phases, each with its own clock setting. The clock is shifted
    // down by a random amount so every status shows up across the phases.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        clk_hz = tprc_pkg::CLK_RESET;
      end else if (phase == 1) begin
        clk_hz = 32'hFFFF_FFFF;
      end else begin
        clk_hz = $urandom >> $urandom_range(0, 26);
        if (clk_hz == 0) clk_hz = 32'd1;
      end
      write_timer_clock(clk_hz);
      if (phase == 2) hold_req = 1'b1;
      if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Mostly valid modes, with a zero field now and then.
        lines   = 8'($urandom_range(1, 255));
        refresh = 10'($urandom_range(1, 1023));
        case ($urandom_range(0, 15))
          0: lines = 8'd0;
          1: refresh = 10'd0;
          default: ;
        endcase
        send_mode(lines, refresh);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- timer_prescaler_reload_calc.f -----
+incdir+hdl
hdl/tprc_pkg.sv
hdl/timer_prescaler_reload_calc.sv
tb/timer_prescaler_reload_calc_checker.sv
tb/timer_prescaler_reload_calc_test.sv
